FILE: hdl/dbs_pkg.sv
// shared types, codes and constants for the deblocking boundary-strength block
`default_nettype none
package dbs_pkg;

	localparam int MOTION_W = 36;
	localparam int REF_PAIR_W = 10;
	localparam int REF_W = 5;
	localparam int IDX_W = 4;
	localparam int SLOT_W = 5;
	localparam int POC_W = 32;
	localparam int CBF_W = 3;
	localparam int BS_W = 6;
	localparam int MODE_W = 2;
	localparam int MV_THRESHOLD = 8;

	localparam logic [MODE_W-1:0] MODE_CU = 2'd0;
	localparam logic [MODE_W-1:0] MODE_AFFINE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TU = 2'd2;
	localparam logic [MODE_W-1:0] MODE_LOAD = 2'd3;

	localparam logic [BS_W-1:0] ALL_STRONG = 6'h2A;

	typedef struct packed {
		logic used;
		logic [IDX_W-1:0] idx;
		logic [POC_W-1:0] poc;
	} ref_pic_t;

	// vector pairings: straight (p0/q0, p1/q1) and crossed (p0/q1, p1/q0)
	typedef struct packed {
		logic d00;
		logic d11;
		logic d01;
		logic d10;
	} mv_differs_t;

	function automatic logic same_pic(input ref_pic_t a, input ref_pic_t b);
		logic res;
		if (a.used != b.used) begin
			res = 1'b0;
		end else begin
			res = !a.used || (a.poc == b.poc);
		end
		return res;
	endfunction

	// coded flags of either side spread into the 2-bit plane fields
	function automatic logic [BS_W-1:0] flag_bits(input logic [CBF_W-1:0] cbf);
		return {1'b0, cbf[2], 1'b0, cbf[1], 1'b0, cbf[0]};
	endfunction

endpackage
`default_nettype wire

FILE: hdl/deblock_boundary_strength.sv
// top level: three-stage boundary-strength pipeline with order-count table
`default_nettype none
// One edge segment is accepted every clock unless stalled. frame_is_p must be written
// only while idle; the block does not enforce it. Stage one reads the order-count
// table (its registered read ports), stage two forms the vector differences, stage
// three compares reference pictures, applies the intra, coded-flag and motion rules
// and holds the result until it is taken. Mode 3 requests load one table entry and
// return zero; the next request already sees it. Table entries must be loaded before
// use. Stages advance independently, so bubbles close up while the output is stalled.
module deblock_boundary_strength #(
	parameter int REFS_PER_LIST = 16,
	parameter int MV_BITS = 18
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic                             cfg_wdata,
	input  wire logic                             in_valid,
	output      logic                             in_stall,
	input  wire logic [dbs_pkg::MODE_W-1:0]       mode,
	input  wire logic                             intra_either,
	input  wire logic [dbs_pkg::CBF_W-1:0]        cbf_p,
	input  wire logic [dbs_pkg::CBF_W-1:0]        cbf_q,
	input  wire logic [dbs_pkg::REF_PAIR_W-1:0]   p_ref_pair,
	input  wire logic [dbs_pkg::REF_PAIR_W-1:0]   q_ref_pair,
	input  wire logic [dbs_pkg::MOTION_W-1:0]     p_motion_l0,
	input  wire logic [dbs_pkg::MOTION_W-1:0]     p_motion_l1,
	input  wire logic [dbs_pkg::MOTION_W-1:0]     q_motion_l0,
	input  wire logic [dbs_pkg::MOTION_W-1:0]     q_motion_l1,
	input  wire logic [dbs_pkg::SLOT_W-1:0]       table_slot,
	input  wire logic [dbs_pkg::POC_W-1:0]        order_count,
	output      logic                             out_valid,
	input  wire logic                             out_stall,
	output      logic [dbs_pkg::BS_W-1:0]         bs_bits
);

	logic frame_is_p_q;
	logic v_s1, v_s2, v_s3;
	logic en1, en2, en3;
	logic accept;

	logic [dbs_pkg::MODE_W-1:0] mode_s1, mode_s2;
	logic intra_s1, intra_s2;
	logic [dbs_pkg::CBF_W-1:0] cbf_s1, cbf_s2;
	logic [dbs_pkg::MOTION_W-1:0] p0_s1, p1_s1, q0_s1, q1_s1;
	dbs_pkg::ref_pic_t rp0_s1, rp1_s1, rq0_s1, rq1_s1;
	dbs_pkg::ref_pic_t rp0_s2, rp1_s2, rq0_s2, rq1_s2;
	dbs_pkg::mv_differs_t differs;
	logic [dbs_pkg::BS_W-1:0] bs_s3;

	logic straight, crossed, motion, p_idx_ne;
	logic [dbs_pkg::BS_W-1:0] flags, bs_next;

	// each stage moves when the one after it can take its contents
	assign en3 = !v_s3 || !out_stall;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign in_stall = !en1;
	assign accept = in_valid && en1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_is_p_q <= 1'b0;
		end else if (cfg_we) begin
			frame_is_p_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= in_valid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			mode_s1 <= mode;
			intra_s1 <= intra_either;
			cbf_s1 <= cbf_p | cbf_q;
			p0_s1 <= p_motion_l0;
			p1_s1 <= p_motion_l1;
			q0_s1 <= q_motion_l0;
			q1_s1 <= q_motion_l1;
		end
		if (en2) begin
			mode_s2 <= mode_s1;
			intra_s2 <= intra_s1;
			cbf_s2 <= cbf_s1;
			rp0_s2 <= rp0_s1;
			rp1_s2 <= rp1_s1;
			rq0_s2 <= rq0_s1;
			rq1_s2 <= rq1_s1;
		end
		if (en3) begin
			bs_s3 <= bs_next;
		end
	end

	dbs_ref_table #(
		.REFS_PER_LIST(REFS_PER_LIST)
	) u_table (
		.clk(clk),
		.rd_en(en1),
		.p_ref_pair(p_ref_pair),
		.q_ref_pair(q_ref_pair),
		.wr_en(accept && (mode == dbs_pkg::MODE_LOAD)),
		.table_slot(table_slot),
		.order_count(order_count),
		.p_l0_s1(rp0_s1),
		.p_l1_s1(rp1_s1),
		.q_l0_s1(rq0_s1),
		.q_l1_s1(rq1_s1)
	);

	dbs_mv_compare #(
		.MV_BITS(MV_BITS)
	) u_mv (
		.clk(clk),
		.en(en2),
		.p_l0(p0_s1),
		.p_l1(p1_s1),
		.q_l0(q0_s1),
		.q_l1(q1_s1),
		.differs(differs)
	);

	always_comb begin
		straight = dbs_pkg::same_pic(rp0_s2, rq0_s2) && dbs_pkg::same_pic(rp1_s2, rq1_s2);
		crossed = dbs_pkg::same_pic(rp0_s2, rq1_s2) && dbs_pkg::same_pic(rp1_s2, rq0_s2);
		p_idx_ne = (rp0_s2.used != rq0_s2.used) ||
			(rp0_s2.used && (rp0_s2.idx != rq0_s2.idx));

		if (frame_is_p_q) begin
			motion = differs.d00 || p_idx_ne;
		end else if (!straight && !crossed) begin
			motion = 1'b1;
		end else if (!dbs_pkg::same_pic(rp0_s2, rp1_s2)) begin
			// two distinct pictures: compare vectors of matching pictures
			if (dbs_pkg::same_pic(rp0_s2, rq0_s2)) begin
				motion = differs.d00 || differs.d11;
			end else begin
				motion = differs.d10 || differs.d01;
			end
		end else begin
			// same picture twice: both pairings must differ
			motion = (differs.d00 || differs.d11) && (differs.d01 || differs.d10);
		end

		flags = dbs_pkg::flag_bits(cbf_s2);

		case (mode_s2)
			dbs_pkg::MODE_CU: begin
				if (intra_s2) begin
					bs_next = dbs_pkg::ALL_STRONG;
				end else if (flags[1:0] == 2'b00) begin
					bs_next = flags | dbs_pkg::BS_W'(motion);
				end else begin
					bs_next = flags;
				end
			end
			dbs_pkg::MODE_AFFINE: begin
				bs_next = dbs_pkg::BS_W'(motion);
			end
			dbs_pkg::MODE_TU: begin
				bs_next = flags;
			end
			default: begin
				bs_next = '0;
			end
		endcase
	end

	assign out_valid = v_s3;
	assign bs_bits = bs_s3;

endmodule
`default_nettype wire

FILE: hdl/dbs_ref_table.sv
// order-count table: one small memory per reference list, two read ports each
`default_nettype none
module dbs_ref_table #(
	parameter int REFS_PER_LIST = 16
) (
	input  wire logic                              clk,
	input  wire logic                              rd_en,
	input  wire logic [dbs_pkg::REF_PAIR_W-1:0]    p_ref_pair,
	input  wire logic [dbs_pkg::REF_PAIR_W-1:0]    q_ref_pair,
	input  wire logic                              wr_en,
	input  wire logic [dbs_pkg::SLOT_W-1:0]        table_slot,
	input  wire logic [dbs_pkg::POC_W-1:0]         order_count,
	output dbs_pkg::ref_pic_t                      p_l0_s1,
	output dbs_pkg::ref_pic_t                      p_l1_s1,
	output dbs_pkg::ref_pic_t                      q_l0_s1,
	output dbs_pkg::ref_pic_t                      q_l1_s1
);

	localparam int ADDR_W = (REFS_PER_LIST > 1) ? $clog2(REFS_PER_LIST) : 1;

	logic [dbs_pkg::POC_W-1:0] mem_l0 [REFS_PER_LIST];
	logic [dbs_pkg::POC_W-1:0] mem_l1 [REFS_PER_LIST];

	logic [dbs_pkg::REF_W-1:0] fp0, fp1, fq0, fq1;
	logic up0, up1, uq0, uq1;
	logic wr_ok;

	function automatic logic idx_used(input logic [dbs_pkg::REF_W-1:0] f);
		return !f[dbs_pkg::REF_W-1] &&
			({1'b0, f[dbs_pkg::IDX_W-1:0]} < dbs_pkg::REF_W'(REFS_PER_LIST));
	endfunction

	assign fp0 = p_ref_pair[dbs_pkg::REF_W-1:0];
	assign fp1 = p_ref_pair[2*dbs_pkg::REF_W-1:dbs_pkg::REF_W];
	assign fq0 = q_ref_pair[dbs_pkg::REF_W-1:0];
	assign fq1 = q_ref_pair[2*dbs_pkg::REF_W-1:dbs_pkg::REF_W];

	assign up0 = idx_used(fp0);
	assign up1 = idx_used(fp1);
	assign uq0 = idx_used(fq0);
	assign uq1 = idx_used(fq1);

	// loads beyond the list length are dropped
	assign wr_ok = wr_en && ({1'b0, table_slot[dbs_pkg::IDX_W-1:0]} <
		dbs_pkg::REF_W'(REFS_PER_LIST));

	always_ff @(posedge clk) begin
		if (wr_ok && !table_slot[dbs_pkg::SLOT_W-1]) begin
			mem_l0[table_slot[ADDR_W-1:0]] <= order_count;
		end
		if (wr_ok && table_slot[dbs_pkg::SLOT_W-1]) begin
			mem_l1[table_slot[ADDR_W-1:0]] <= order_count;
		end
		if (rd_en) begin
			p_l0_s1.poc <= mem_l0[fp0[ADDR_W-1:0]];
			q_l0_s1.poc <= mem_l0[fq0[ADDR_W-1:0]];
			p_l1_s1.poc <= mem_l1[fp1[ADDR_W-1:0]];
			q_l1_s1.poc <= mem_l1[fq1[ADDR_W-1:0]];
			p_l0_s1.used <= up0;
			p_l1_s1.used <= up1;
			q_l0_s1.used <= uq0;
			q_l1_s1.used <= uq1;
			p_l0_s1.idx <= fp0[dbs_pkg::IDX_W-1:0];
			p_l1_s1.idx <= fp1[dbs_pkg::IDX_W-1:0];
			q_l0_s1.idx <= fq0[dbs_pkg::IDX_W-1:0];
			q_l1_s1.idx <= fq1[dbs_pkg::IDX_W-1:0];
		end
	end

endmodule
`default_nettype wire

FILE: hdl/dbs_mv_compare.sv
// motion vector differences for the four pairings, then the threshold check
`default_nettype none
module dbs_mv_compare #(
	parameter int MV_BITS = 18
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic [dbs_pkg::MOTION_W-1:0]    p_l0,
	input  wire logic [dbs_pkg::MOTION_W-1:0]    p_l1,
	input  wire logic [dbs_pkg::MOTION_W-1:0]    q_l0,
	input  wire logic [dbs_pkg::MOTION_W-1:0]    q_l1,
	output dbs_pkg::mv_differs_t                 differs
);

	localparam logic signed [MV_BITS:0] THRESH = (MV_BITS+1)'(dbs_pkg::MV_THRESHOLD);
	localparam logic signed [MV_BITS:0] THRESH_NEG = -THRESH;

	logic signed [MV_BITS:0] dx_s2 [4];
	logic signed [MV_BITS:0] dy_s2 [4];
	logic [3:0] far;

	function automatic logic signed [MV_BITS:0] sub_comp(
		input logic [dbs_pkg::MOTION_W-1:0] a,
		input logic [dbs_pkg::MOTION_W-1:0] b,
		input logic sel_y
	);
		logic [63:0] ea;
		logic [63:0] eb;
		logic [MV_BITS-1:0] ca;
		logic [MV_BITS-1:0] cb;
		ea = 64'(a);
		eb = 64'(b);
		ca = sel_y ? ea[2*MV_BITS-1:MV_BITS] : ea[MV_BITS-1:0];
		cb = sel_y ? eb[2*MV_BITS-1:MV_BITS] : eb[MV_BITS-1:0];
		return $signed({ca[MV_BITS-1], ca}) - $signed({cb[MV_BITS-1], cb});
	endfunction

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s2[0] <= sub_comp(p_l0, q_l0, 1'b0);
			dy_s2[0] <= sub_comp(p_l0, q_l0, 1'b1);
			dx_s2[1] <= sub_comp(p_l1, q_l1, 1'b0);
			dy_s2[1] <= sub_comp(p_l1, q_l1, 1'b1);
			dx_s2[2] <= sub_comp(p_l0, q_l1, 1'b0);
			dy_s2[2] <= sub_comp(p_l0, q_l1, 1'b1);
			dx_s2[3] <= sub_comp(p_l1, q_l0, 1'b0);
			dy_s2[3] <= sub_comp(p_l1, q_l0, 1'b1);
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			far[i] = (dx_s2[i] >= THRESH) || (dx_s2[i] <= THRESH_NEG) ||
				(dy_s2[i] >= THRESH) || (dy_s2[i] <= THRESH_NEG);
		end
	end

	assign differs.d00 = far[0];
	assign differs.d11 = far[1];
	assign differs.d01 = far[2];
	assign differs.d10 = far[3];

endmodule
`default_nettype wire

FILE: tb/sv/dbs_tb_pkg.sv
// request type and strength predictor for the boundary-strength testbench
package dbs_tb_pkg;
	import dbs_pkg::*;

	localparam int REFS_PER_LIST = 16;
	localparam int MV_BITS = 18;
	localparam int TABLE_STRIDE = 16;
	localparam int TABLE_SIZE = 32;
	localparam logic [REF_W-1:0] REF_UNUSED = 5'h10;

	typedef struct {
		logic [MODE_W-1:0] mode;
		logic intra_either;
		logic [CBF_W-1:0] cbf_p;
		logic [CBF_W-1:0] cbf_q;
		logic [REF_PAIR_W-1:0] p_ref_pair;
		logic [REF_PAIR_W-1:0] q_ref_pair;
		logic [MOTION_W-1:0] p_motion_l0;
		logic [MOTION_W-1:0] p_motion_l1;
		logic [MOTION_W-1:0] q_motion_l0;
		logic [MOTION_W-1:0] q_motion_l1;
		logic [SLOT_W-1:0] table_slot;
		logic [POC_W-1:0] order_count;
	} edge_seg_t;

	typedef struct packed {
		bit used;
		logic [POC_W-1:0] poc;
	} picture_t;

	class strength_predictor;
		logic [POC_W-1:0] poc_table [TABLE_SIZE];
		bit frame_is_p;
		logic [BS_W-1:0] pending_strength [$];
		int mismatches;
		int checked;

		function new();
			foreach (poc_table[i]) poc_table[i] = '0;
			frame_is_p = 1'b0;
			mismatches = 0;
			checked = 0;
		endfunction

		static function longint component(logic [MOTION_W-1:0] v, int which);
			logic signed [MV_BITS-1:0] c;
			c = v[which*MV_BITS +: MV_BITS];
			return longint'(c);
		endfunction

		static function bit far_apart(logic [MOTION_W-1:0] a, logic [MOTION_W-1:0] b);
			longint dx;
			longint dy;
			dx = component(a, 0) - component(b, 0);
			dy = component(a, 1) - component(b, 1);
			if (dx < 0) dx = -dx;
			if (dy < 0) dy = -dy;
			return dx >= MV_THRESHOLD || dy >= MV_THRESHOLD;
		endfunction

		// -1 for a negative or out-of-list index
		static function int list_index(logic [REF_PAIR_W-1:0] pair, int list);
			logic [REF_W-1:0] f;
			f = pair[list*REF_W +: REF_W];
			if (f[REF_W-1] || f >= REFS_PER_LIST) return -1;
			return int'(f);
		endfunction

		function picture_t picture_of(logic [REF_PAIR_W-1:0] pair, int list);
			picture_t p;
			int idx;
			idx = list_index(pair, list);
			p.used = idx >= 0;
			p.poc = p.used ? poc_table[list*TABLE_STRIDE + idx] : '0;
			return p;
		endfunction

		static function bit same_picture(picture_t a, picture_t b);
			return a.used == b.used && (!a.used || a.poc == b.poc);
		endfunction

		function bit motion_luma(edge_seg_t s);
			picture_t rp0, rp1, rq0, rq1;
			bit straight, crossed;
			if (frame_is_p) begin
				return far_apart(s.p_motion_l0, s.q_motion_l0) ||
					list_index(s.p_ref_pair, 0) != list_index(s.q_ref_pair, 0);
			end
			rp0 = picture_of(s.p_ref_pair, 0);
			rp1 = picture_of(s.p_ref_pair, 1);
			rq0 = picture_of(s.q_ref_pair, 0);
			rq1 = picture_of(s.q_ref_pair, 1);
			straight = same_picture(rp0, rq0) && same_picture(rp1, rq1);
			crossed = same_picture(rp0, rq1) && same_picture(rp1, rq0);
			if (!straight && !crossed) return 1'b1;
			if (!same_picture(rp0, rp1)) begin
				if (same_picture(rp0, rq0)) begin
					return far_apart(s.p_motion_l0, s.q_motion_l0) ||
						far_apart(s.p_motion_l1, s.q_motion_l1);
				end
				return far_apart(s.p_motion_l1, s.q_motion_l0) ||
					far_apart(s.p_motion_l0, s.q_motion_l1);
			end
			// one picture on both lists: either pairing may match
			return (far_apart(s.p_motion_l0, s.q_motion_l0) ||
				far_apart(s.p_motion_l1, s.q_motion_l1)) &&
				(far_apart(s.p_motion_l0, s.q_motion_l1) ||
				far_apart(s.p_motion_l1, s.q_motion_l0));
		endfunction

		static function logic [BS_W-1:0] coded_bits(edge_seg_t s);
			logic [CBF_W-1:0] c;
			c = s.cbf_p | s.cbf_q;
			return {1'b0, c[2], 1'b0, c[1], 1'b0, c[0]};
		endfunction

		function void note_request(edge_seg_t s);
			logic [BS_W-1:0] bs;
			bs = '0;
			case (s.mode)
				MODE_CU: begin
					if (s.intra_either) begin
						bs = ALL_STRONG;
					end else begin
						bs = coded_bits(s);
						if (bs[1:0] == 2'b00) bs[0] = motion_luma(s);
					end
				end
				MODE_AFFINE: bs[0] = motion_luma(s);
				MODE_TU: bs = coded_bits(s);
				default: begin
					if (s.table_slot[IDX_W-1:0] < REFS_PER_LIST)
						poc_table[s.table_slot] = s.order_count;
				end
			endcase
			pending_strength.push_back(bs);
		endfunction

		function void check_strength(logic [BS_W-1:0] got);
			logic [BS_W-1:0] want;
			if (pending_strength.size() == 0) begin
				$error("bs_bits: expected nothing, got %h", got);
				mismatches++;
				return;
			end
			want = pending_strength.pop_front();
			checked++;
			if (got !== want) begin
				$error("bs_bits: expected %h, got %h", want, got);
				mismatches++;
			end
		endfunction
	endclass

endpackage

FILE: tb/sv/deblock_boundary_strength_tb.sv
// top of the boundary-strength testbench: clock, reset, request drivers and result checks
module deblock_boundary_strength_tb;
	import dbs_pkg::*;
	import dbs_tb_pkg::*;

	localparam int DRAIN_CYCLES = 8;
	localparam int IDLE_PCT = 6;
	localparam int PHASE_ITEMS = 310;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;
	logic in_valid;
	logic in_stall;
	logic [MODE_W-1:0] mode;
	logic intra_either;
	logic [CBF_W-1:0] cbf_p;
	logic [CBF_W-1:0] cbf_q;
	logic [REF_PAIR_W-1:0] p_ref_pair;
	logic [REF_PAIR_W-1:0] q_ref_pair;
	logic [MOTION_W-1:0] p_motion_l0;
	logic [MOTION_W-1:0] p_motion_l1;
	logic [MOTION_W-1:0] q_motion_l0;
	logic [MOTION_W-1:0] q_motion_l1;
	logic [SLOT_W-1:0] table_slot;
	logic [POC_W-1:0] order_count;
	logic out_valid;
	logic out_stall;
	logic [BS_W-1:0] bs_bits;

	bit quiet_run;
	strength_predictor bs_predict;
	// what the generator knows has been loaded, so no unloaded entry is ever read
	logic [POC_W-1:0] shadow_poc [TABLE_SIZE];
	bit shadow_loaded [TABLE_SIZE];
	int mode_count [4];

	deblock_boundary_strength #(
		.REFS_PER_LIST(REFS_PER_LIST),
		.MV_BITS(MV_BITS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.mode(mode),
		.intra_either(intra_either),
		.cbf_p(cbf_p),
		.cbf_q(cbf_q),
		.p_ref_pair(p_ref_pair),
		.q_ref_pair(q_ref_pair),
		.p_motion_l0(p_motion_l0),
		.p_motion_l1(p_motion_l1),
		.q_motion_l0(q_motion_l0),
		.q_motion_l1(q_motion_l1),
		.table_slot(table_slot),
		.order_count(order_count),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.bs_bits(bs_bits)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [MOTION_W-1:0] vec(int x, int y);
		return {MV_BITS'(y), MV_BITS'(x)};
	endfunction

	function automatic logic [REF_PAIR_W-1:0] refs(logic [REF_W-1:0] l0, logic [REF_W-1:0] l1);
		return {l1, l0};
	endfunction

	function automatic logic [REF_W-1:0] unused_ref();
		return REF_W'($urandom_range(2 * TABLE_STRIDE - 1, TABLE_STRIDE));
	endfunction

	function automatic logic [REF_W-1:0] pick_ref(int list);
		int hits [$];
		if ($urandom_range(99) < 20) return unused_ref();
		for (int i = 0; i < REFS_PER_LIST; i++)
			if (shadow_loaded[list*TABLE_STRIDE + i]) hits.push_back(i);
		if (hits.size() == 0) return unused_ref();
		return REF_W'(hits[$urandom_range(hits.size() - 1)]);
	endfunction

	// an index in list that names the same picture as src in src_list
	function automatic logic [REF_W-1:0] match_ref(int list, int src_list, logic [REF_W-1:0] src);
		int hits [$];
		logic [POC_W-1:0] want;
		if (src[REF_W-1]) return unused_ref();
		want = shadow_poc[src_list*TABLE_STRIDE + src];
		for (int i = 0; i < REFS_PER_LIST; i++)
			if (shadow_loaded[list*TABLE_STRIDE + i] && shadow_poc[list*TABLE_STRIDE + i] == want)
				hits.push_back(i);
		if (hits.size() == 0) return pick_ref(list);
		return REF_W'(hits[$urandom_range(hits.size() - 1)]);
	endfunction

	function automatic logic [MV_BITS-1:0] rand_comp();
		case ($urandom_range(9))
			0: return {1'b0, {(MV_BITS-1){1'b1}}};
			1: return {1'b1, {(MV_BITS-1){1'b0}}};
			2, 3, 4, 5: return MV_BITS'($urandom_range(80)) - MV_BITS'(40);
			default: return MV_BITS'($urandom);
		endcase
	endfunction

	function automatic logic [MOTION_W-1:0] rand_vec();
		return {rand_comp(), rand_comp()};
	endfunction

	// steps of -9..9 per component straddle the threshold, wrapping at the extremes
	function automatic logic [MOTION_W-1:0] mate_vec(logic [MOTION_W-1:0] v);
		logic [MV_BITS-1:0] x, y;
		if ($urandom_range(9) < 3) return rand_vec();
		x = v[MV_BITS-1:0] + MV_BITS'($urandom_range(18)) - MV_BITS'(9);
		y = v[MOTION_W-1:MV_BITS] + MV_BITS'($urandom_range(18)) - MV_BITS'(9);
		return {y, x};
	endfunction

	function automatic logic [POC_W-1:0] rand_poc();
		int r;
		r = $urandom_range(99);
		if (r < 40) return POC_W'($urandom_range(7));
		if (r < 45) return 32'h8000_0000;
		if (r < 50) return 32'hFFFF_FFFF;
		return POC_W'($urandom);
	endfunction

	function automatic edge_seg_t random_segment();
		edge_seg_t s;
		int r;
		int pairing;
		logic [REF_W-1:0] p0r, p1r, q0r, q1r;
		r = $urandom_range(99);
		s.mode = r < 15 ? MODE_LOAD : r < 55 ? MODE_CU : r < 80 ? MODE_AFFINE : MODE_TU;
		s.intra_either = $urandom_range(3) == 0;
		if ($urandom_range(1)) begin
			s.cbf_p = '0;
			s.cbf_q = '0;
		end else begin
			s.cbf_p = CBF_W'($urandom);
			s.cbf_q = CBF_W'($urandom);
		end
		p0r = pick_ref(0);
		p1r = pick_ref(1);
		s.p_motion_l0 = rand_vec();
		s.p_motion_l1 = $urandom_range(3) == 0 ? mate_vec(s.p_motion_l0) : rand_vec();
		pairing = $urandom_range(99);
		if (pairing < 50) begin
			q0r = $urandom_range(1) ? p0r : match_ref(0, 0, p0r);
			q1r = $urandom_range(1) ? p1r : match_ref(1, 1, p1r);
			s.q_motion_l0 = mate_vec(s.p_motion_l0);
			s.q_motion_l1 = mate_vec(s.p_motion_l1);
		end else if (pairing < 75) begin
			q0r = match_ref(0, 1, p1r);
			q1r = match_ref(1, 0, p0r);
			s.q_motion_l0 = mate_vec(s.p_motion_l1);
			s.q_motion_l1 = mate_vec(s.p_motion_l0);
		end else begin
			q0r = pick_ref(0);
			q1r = pick_ref(1);
			s.q_motion_l0 = rand_vec();
			s.q_motion_l1 = rand_vec();
		end
		s.p_ref_pair = refs(p0r, p1r);
		s.q_ref_pair = refs(q0r, q1r);
		s.table_slot = SLOT_W'($urandom);
		s.order_count = rand_poc();
		return s;
	endfunction

	task automatic send_segment(input edge_seg_t s);
		if (s.mode == MODE_LOAD) begin
			shadow_poc[s.table_slot] = s.order_count;
			shadow_loaded[s.table_slot] = 1'b1;
		end
		@(negedge clk);
		while (!quiet_run && $urandom_range(99) < IDLE_PCT) begin
			in_valid = 1'b0;
			@(negedge clk);
		end
		mode = s.mode;
		intra_either = s.intra_either;
		cbf_p = s.cbf_p;
		cbf_q = s.cbf_q;
		p_ref_pair = s.p_ref_pair;
		q_ref_pair = s.q_ref_pair;
		p_motion_l0 = s.p_motion_l0;
		p_motion_l1 = s.p_motion_l1;
		q_motion_l0 = s.q_motion_l0;
		q_motion_l1 = s.q_motion_l1;
		table_slot = s.table_slot;
		order_count = s.order_count;
		in_valid = 1'b1;
		do @(posedge clk); while (in_stall);
		bs_predict.note_request(s);
		mode_count[s.mode]++;
	endtask

	task automatic send_fields(
		input logic [MODE_W-1:0] m, input logic intra,
		input logic [CBF_W-1:0] cp, input logic [CBF_W-1:0] cq,
		input logic [REF_PAIR_W-1:0] pr, input logic [REF_PAIR_W-1:0] qr,
		input logic [MOTION_W-1:0] p0, input logic [MOTION_W-1:0] p1,
		input logic [MOTION_W-1:0] q0, input logic [MOTION_W-1:0] q1
	);
		edge_seg_t s;
		s = '{m, intra, cp, cq, pr, qr, p0, p1, q0, q1, '0, '0};
		send_segment(s);
	endtask

	task automatic load_entry(input logic [SLOT_W-1:0] slot, input logic [POC_W-1:0] poc);
		edge_seg_t s;
		s = '{MODE_LOAD, 1'b0, '0, '0, refs(REF_UNUSED, REF_UNUSED), refs(REF_UNUSED, REF_UNUSED),
			'0, '0, '0, '0, slot, poc};
		send_segment(s);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid = 1'b0;
		while (bs_predict.pending_strength.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_picture_type(input bit is_p);
		wait_drained();
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = is_p;
		@(negedge clk);
		cfg_we = 1'b0;
		bs_predict.frame_is_p = is_p;
	endtask

	initial begin
		bs_predict = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 1'b0;
		in_valid = 1'b0;
		mode = MODE_CU;
		intra_either = 1'b0;
		cbf_p = '0;
		cbf_q = '0;
		p_ref_pair = refs(REF_UNUSED, REF_UNUSED);
		q_ref_pair = refs(REF_UNUSED, REF_UNUSED);
		p_motion_l0 = '0;
		p_motion_l1 = '0;
		q_motion_l0 = '0;
		q_motion_l1 = '0;
		table_slot = '0;
		order_count = '0;
		quiet_run = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		set_picture_type(1'b0);
		// one picture in both lists, plus two pictures swapped between the lists
		load_entry(5'd0, 32'h8000_0000);
		load_entry(5'd16, 32'h8000_0000);
		load_entry(5'd15, 32'hFFFF_FFFF);
		load_entry(5'd31, 32'h0);
		load_entry(5'd1, 32'd5);
		load_entry(5'd17, 32'd9);
		load_entry(5'd2, 32'd9);
		load_entry(5'd18, 32'd5);
		send_fields(MODE_CU, 1'b1, 3'd0, 3'd0, refs(REF_UNUSED, REF_UNUSED),
			refs(REF_UNUSED, REF_UNUSED), '0, '0, '0, '0);
		send_fields(MODE_CU, 1'b0, 3'd7, 3'd0, refs(REF_UNUSED, REF_UNUSED),
			refs(REF_UNUSED, REF_UNUSED), '0, '0, '0, '0);
		send_fields(MODE_TU, 1'b1, 3'd0, 3'd5, refs(5'd0, 5'd0), refs(5'd1, 5'd2),
			vec(0, 0), vec(500, 0), vec(-500, 0), vec(0, 0));
		// different negative indices both mean unused
		send_fields(MODE_AFFINE, 1'b1, 3'd7, 3'd7, refs(5'h10, 5'h1F), refs(5'h1F, 5'h10),
			vec(3, 3), vec(0, 0), vec(3, 3), vec(0, 0));
		send_fields(MODE_CU, 1'b0, 3'd2, 3'd0, refs(5'd0, REF_UNUSED), refs(5'd0, REF_UNUSED),
			vec(131071, 131071), '0, vec(-131072, 0), '0);
		send_fields(MODE_AFFINE, 1'b0, 3'd0, 3'd0, refs(5'd0, REF_UNUSED), refs(5'd0, REF_UNUSED),
			vec(0, 0), '0, vec(7, -7), '0);
		send_fields(MODE_AFFINE, 1'b0, 3'd0, 3'd0, refs(5'd0, REF_UNUSED), refs(5'd0, REF_UNUSED),
			vec(0, 0), '0, vec(0, 8), '0);
		// unused against a used entry holding zero
		send_fields(MODE_AFFINE, 1'b0, 3'd0, 3'd0, refs(REF_UNUSED, REF_UNUSED),
			refs(REF_UNUSED, 5'd15), '0, '0, '0, '0);
		send_fields(MODE_AFFINE, 1'b0, 3'd0, 3'd0, refs(5'd0, 5'd0), refs(5'd0, 5'd0),
			vec(0, 0), vec(100, 0), vec(100, 0), vec(0, 0));
		send_fields(MODE_AFFINE, 1'b0, 3'd0, 3'd0, refs(5'd0, 5'd0), refs(5'd0, 5'd0),
			vec(0, 0), vec(100, 0), vec(50, 0), vec(0, 0));
		send_fields(MODE_AFFINE, 1'b0, 3'd0, 3'd0, refs(5'd1, 5'd1), refs(5'd2, 5'd2),
			vec(10, 10), vec(-20, 3), vec(-20, 3), vec(10, 10));
		send_fields(MODE_AFFINE, 1'b0, 3'd0, 3'd0, refs(5'd1, 5'd1), refs(5'd2, 5'd2),
			vec(10, 10), vec(-20, 3), vec(-20, 3), vec(10, 18));
		send_fields(MODE_CU, 1'b0, 3'd4, 3'd0, refs(5'd0, REF_UNUSED), refs(5'd1, REF_UNUSED),
			'0, '0, '0, '0);

		set_picture_type(1'b1);
		send_fields(MODE_CU, 1'b0, 3'd0, 3'd0, refs(5'd0, REF_UNUSED), refs(5'd1, REF_UNUSED),
			'0, '0, '0, '0);
		// list 1 plays no part in a P picture
		send_fields(MODE_AFFINE, 1'b0, 3'd0, 3'd0, refs(5'd0, 5'd1), refs(5'd0, 5'd2),
			vec(4, 4), vec(0, 0), vec(0, 0), vec(9000, 0));
		send_fields(MODE_AFFINE, 1'b0, 3'd0, 3'd0, refs(5'd0, REF_UNUSED), refs(5'd0, REF_UNUSED),
			vec(-131072, -131072), '0, vec(-131065, -131072), '0);
		send_fields(MODE_AFFINE, 1'b0, 3'd0, 3'd0, refs(REF_UNUSED, 5'd0), refs(REF_UNUSED, 5'd1),
			vec(0, 0), '0, vec(0, -8), '0);

		// alternate picture types; the third phase runs with no gaps on either side
		for (int ph = 0; ph < 4; ph++) begin
			set_picture_type(ph[0]);
			quiet_run = ph == 2;
			repeat (PHASE_ITEMS) send_segment(random_segment());
		end
		quiet_run = 1'b0;
		wait_drained();

		$display("%0d edge segments: %0d cu, %0d affine, %0d transform, %0d table loads",
			mode_count[MODE_CU] + mode_count[MODE_AFFINE] + mode_count[MODE_TU] +
			mode_count[MODE_LOAD], mode_count[MODE_CU], mode_count[MODE_AFFINE],
			mode_count[MODE_TU], mode_count[MODE_LOAD]);
		$display("%0d strengths compared over P and B pictures, with and without flow gaps",
			bs_predict.checked);
		if (bs_predict.mismatches == 0 && bs_predict.pending_strength.size() == 0) begin
			$display("deblock_boundary_strength_tb OK");
		end else begin
			$display("deblock_boundary_strength_tb NOT OK");
		end
		$finish;
	end

	initial begin
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			out_stall = !quiet_run && $urandom_range(99) < IDLE_PCT;
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) bs_predict.check_strength(bs_bits);
		end
	end

	// far beyond the time a correct run needs
	initial begin
		#2000000;
		$display("deblock_boundary_strength_tb NOT OK");
		$finish;
	end

endmodule

FILE: files.f
hdl/dbs_pkg.sv
hdl/dbs_ref_table.sv
hdl/dbs_mv_compare.sv
hdl/deblock_boundary_strength.sv
tb/sv/dbs_tb_pkg.sv
tb/sv/deblock_boundary_strength_tb.sv
